>>> hdl/cft_pkg.sv
// cft_pkg: types, character codes and delimiter codes for the csv field tokenizer
// no dependencies; imported by cft_step and csv_field_tokenizer
`default_nettype none

package cft_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [1:0] DELIM_DETECT = 2'd0;
    localparam logic [1:0] DELIM_COMMA  = 2'd1;
    localparam logic [1:0] DELIM_SEMI   = 2'd2;
    localparam logic [1:0] DELIM_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        EV_CHAR       = 2'd0,
        EV_FIELD      = 2'd1,
        EV_FIELD_LINE = 2'd2,
        EV_LINE       = 2'd3
    } t_event_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        t_event_kind event_kind;
        logic [7:0]  field_byte;
        logic [1:0]  delimiter_seen;
    } t_out_beat;

    typedef struct packed {
        logic       in_quotes;
        logic       quote_closed;
        logic [7:0] previous_byte;
        logic       field_is_empty;
        logic       escape_pending;
        logic [1:0] locked_delimiter;
    } t_tok_state;

    // register code 3 behaves as detect
    function automatic logic [1:0] start_code(input logic [1:0] cfg);
        start_code = (cfg == DELIM_UNUSED) ? DELIM_DETECT : cfg;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cft_step.sv
// cft_step: next-state and event logic for one byte of the csv tokenizer
// depends on cft_pkg
`default_nettype none

module cft_step
    import cft_pkg::*;
(
    input  wire t_tok_state i_state,
    input  wire t_in_beat   i_beat,
    input  wire logic [1:0] i_start_delim,
    output t_tok_state      o_state,
    output logic            o_emit,
    output t_out_beat       o_event
);

    logic [7:0] c;
    logic       open_q;
    logic [1:0] dcode;
    t_tok_state cleared;

    assign c      = i_beat.in_byte;
    assign open_q = i_state.in_quotes && !i_state.quote_closed;
    assign dcode  = (c == CH_COMMA) ? DELIM_COMMA : DELIM_SEMI;

    always_comb begin
        cleared                = i_state;
        cleared.in_quotes      = 1'b0;
        cleared.quote_closed   = 1'b0;
        cleared.previous_byte  = 8'd0;
        cleared.field_is_empty = 1'b1;
        cleared.escape_pending = 1'b0;
    end

    always_comb begin
        o_state                = i_state;
        o_emit                 = 1'b0;
        o_event.event_kind     = EV_CHAR;
        o_event.field_byte     = 8'd0;
        o_event.delimiter_seen = i_state.locked_delimiter;

        if (i_beat.end_of_input || (!i_state.escape_pending && c == CH_LF && !open_q)) begin
            // line end
            o_emit                   = 1'b1;
            o_event.event_kind       = i_state.field_is_empty ? EV_LINE : EV_FIELD_LINE;
            o_state                  = cleared;
            o_state.locked_delimiter = start_code(i_start_delim);
        end else if (i_state.escape_pending) begin
            o_state.escape_pending = 1'b0;
            o_state.previous_byte  = c;
            // backslash-newline is dropped
            if (c != CH_LF) begin
                o_emit                 = 1'b1;
                o_event.field_byte     = c;
                o_state.field_is_empty = 1'b0;
            end
        end else if (c == CH_LF) begin
            o_state.previous_byte  = c;
            o_emit                 = 1'b1;
            o_event.field_byte     = c;
            o_state.field_is_empty = 1'b0;
        end else if (c == CH_QUOTE) begin
            if (i_state.previous_byte == CH_QUOTE) begin
                // doubled quote gives one quote
                o_state.quote_closed   = 1'b0;
                o_state.previous_byte  = 8'd0;
                o_emit                 = 1'b1;
                o_event.field_byte     = c;
                o_state.field_is_empty = 1'b0;
            end else if (i_state.in_quotes) begin
                o_state.quote_closed  = 1'b1;
                o_state.previous_byte = c;
            end else if (i_state.field_is_empty) begin
                o_state.in_quotes     = 1'b1;
                o_state.previous_byte = 8'd0;
            end else begin
                o_state.previous_byte  = c;
                o_emit                 = 1'b1;
                o_event.field_byte     = c;
                o_state.field_is_empty = 1'b0;
            end
        end else if (c == CH_COMMA || c == CH_SEMI) begin
            if (open_q || (i_state.locked_delimiter != DELIM_DETECT &&
                           i_state.locked_delimiter != dcode)) begin
                // inside an open quote, or when the other delimiter is locked, it is plain data
                o_state.previous_byte  = c;
                o_emit                 = 1'b1;
                o_event.field_byte     = c;
                o_state.field_is_empty = 1'b0;
            end else begin
                o_state                  = cleared;
                o_state.locked_delimiter = dcode;
                o_emit                   = 1'b1;
                o_event.event_kind       = EV_FIELD;
                o_event.delimiter_seen   = dcode;
            end
        end else if (c == CH_BSLASH) begin
            o_state.escape_pending = 1'b1;
        end else begin
            o_state.previous_byte = c;
            // carriage returns and bytes after a closing quote are dropped
            if (!i_state.quote_closed && c != CH_CR) begin
                o_emit                 = 1'b1;
                o_event.field_byte     = c;
                o_state.field_is_empty = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/csv_field_tokenizer.sv
// csv_field_tokenizer: top level with input register, tokenizer state and result register
// depends on cft_pkg and cft_step
//
// Usage: the input channel carries one beat per raw byte (or an end-of-input
// mark) on i_in_valid / o_in_stall / i_in_data; a beat is taken at a clock edge
// with valid high and stall low. The output channel gives at most one event per
// input beat on o_out_valid / i_out_stall / o_out_data, in input order.
// Order: a taken beat is held first in the input register; its event then enters
// the result register, which drives o_out_valid, once that register is free.
// Throughput: one byte per cycle while the output is not stalled; the per-byte
// state update is one short compare-and-select step between the two registers,
// so a byte can be taken at every edge unless o_in_stall is high.
// Bytes that give no event (such as opening and closing quotes, backslash, carriage return) still take one
// slot in the input register and then vanish.
// When the receiver stalls, the result register holds its event; the input
// register, if it holds a byte, keeps it and o_in_stall goes high until the event is taken.
// i_cfg_we / i_cfg_data write the start delimiter; it takes effect at the next
// line start. Reset (i_rst_n low, synchronous) empties both registers and
// returns the tokenizer to the start of a line with detect mode.
`default_nettype none

module csv_field_tokenizer
    import cft_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_beat   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_beat       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_beat   r_in_data;
    logic       r_out_valid;
    t_out_beat  r_out_data;
    t_tok_state r_state;
    logic [1:0] r_start_delim;

    t_tok_state n_state;
    logic       step_emit;
    t_out_beat  step_event;
    logic       out_free;
    logic       advance;

    cft_step u_step (
        .i_state       (r_state),
        .i_beat        (r_in_data),
        .i_start_delim (r_start_delim),
        .o_state       (n_state),
        .o_emit        (step_emit),
        .o_event       (step_event)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= DELIM_DETECT;
        end else if (i_cfg_we) begin
            r_start_delim <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // tokenizer state moves on as each beat leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.in_quotes        <= 1'b0;
            r_state.quote_closed     <= 1'b0;
            r_state.previous_byte    <= 8'd0;
            r_state.field_is_empty   <= 1'b1;
            r_state.escape_pending   <= 1'b0;
            r_state.locked_delimiter <= DELIM_DETECT;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_emit;
        end
        if (advance && step_emit) begin
            r_out_data <= step_event;
        end
    end

endmodule

`default_nettype wire

>>> test/csv_field_tokenizer_tb.sv
// csv_field_tokenizer_tb: self-checking bench for the csv field tokenizer, with a
// driver and a monitor on the valid/stall channels and an event predictor
// depends on cft_pkg and csv_field_tokenizer
module csv_field_tokenizer_tb;
    import cft_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = DELIM_DETECT;

    csv_field_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_beat  pending_beats[$];
    t_out_beat expected_events[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_errors = 0;
    int n_beats = 0;
    int n_events = 0;
    int n_line_ends = 0;
    int n_field_ends = 0;
    int cycle_count = 0;

    // predictor copy of the tokenizer
    logic [1:0] start_delim = DELIM_DETECT;
    logic       tok_in_quotes = 1'b0;
    logic       tok_quote_closed = 1'b0;
    logic [7:0] tok_prev = 8'h00;
    logic       tok_empty = 1'b1;
    logic       tok_escape = 1'b0;
    logic [1:0] tok_lock = DELIM_DETECT;

    function automatic void clear_field_state();
        tok_in_quotes = 1'b0;
        tok_quote_closed = 1'b0;
        tok_prev = 8'h00;
        tok_empty = 1'b1;
        tok_escape = 1'b0;
    endfunction

    function automatic bit tokenize_beat(input t_in_beat b, output t_out_beat ev);
        logic [7:0]  c;
        logic [1:0]  code;
        bit          open_q;
        bit          hit;
        bit          line_end;
        t_event_kind kind;
        c = b.in_byte;
        open_q = tok_in_quotes && !tok_quote_closed;
        hit = 1'b1;
        line_end = 1'b0;
        kind = EV_CHAR;
        if (b.end_of_input) begin
            line_end = 1'b1;
        end else if (tok_escape) begin
            tok_escape = 1'b0;
            tok_prev = c;
            if (c == CH_LF) hit = 1'b0;
        end else if (c == CH_LF) begin
            if (open_q) tok_prev = c;
            else line_end = 1'b1;
        end else if (c == CH_QUOTE) begin
            if (tok_prev == CH_QUOTE) begin
                // doubled quote gives one quote and reopens
                tok_quote_closed = 1'b0;
                tok_prev = 8'h00;
            end else if (tok_in_quotes) begin
                tok_quote_closed = 1'b1;
                tok_prev = c;
                hit = 1'b0;
            end else if (tok_empty) begin
                tok_in_quotes = 1'b1;
                tok_prev = 8'h00;
                hit = 1'b0;
            end else begin
                tok_prev = c;
            end
        end else if (c == CH_COMMA || c == CH_SEMI) begin
            code = (c == CH_COMMA) ? DELIM_COMMA : DELIM_SEMI;
            if (open_q || (tok_lock != DELIM_DETECT && tok_lock != code)) begin
                tok_prev = c;
            end else begin
                tok_lock = code;
                clear_field_state();
                kind = EV_FIELD;
            end
        end else if (c == CH_BSLASH) begin
            tok_escape = 1'b1;
            hit = 1'b0;
        end else begin
            tok_prev = c;
            if (tok_quote_closed || c == CH_CR) hit = 1'b0;
        end
        ev = '0;
        ev.delimiter_seen = tok_lock;
        if (line_end) begin
            kind = tok_empty ? EV_LINE : EV_FIELD_LINE;
            clear_field_state();
            tok_lock = (start_delim == DELIM_UNUSED) ? DELIM_DETECT : start_delim;
        end else if (kind == EV_CHAR && hit) begin
            tok_empty = 1'b0;
        end
        ev.event_kind = kind;
        ev.field_byte = (kind == EV_CHAR) ? c : 8'h00;
        return hit;
    endfunction

    // driver: takes beats from the pending queue, idles at random
    always @(posedge i_clk) begin
        t_out_beat ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                n_beats++;
                if (tokenize_beat(i_in_data, ev)) expected_events.push_back(ev);
            end
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_beats.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted event against the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_events++;
                if (o_out_data.event_kind inside {EV_FIELD_LINE, EV_LINE}) n_line_ends++;
                if (o_out_data.event_kind == EV_FIELD) n_field_ends++;
                if (expected_events.size() == 0) begin
                    $display("%0t: event with none expected: kind %0d byte %h delim %0d",
                             $time, o_out_data.event_kind, o_out_data.field_byte,
                             o_out_data.delimiter_seen);
                    n_errors++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_out_data.event_kind !== want.event_kind) begin
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $time, want.event_kind, o_out_data.event_kind);
                        n_errors++;
                    end
                    if (o_out_data.field_byte !== want.field_byte) begin
                        $display("%0t: field_byte expected %h actual %h",
                                 $time, want.field_byte, o_out_data.field_byte);
                        n_errors++;
                    end
                    if (o_out_data.delimiter_seen !== want.delimiter_seen) begin
                        $display("%0t: delimiter_seen expected %0d actual %0d",
                                 $time, want.delimiter_seen, o_out_data.delimiter_seen);
                        n_errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats pending and %0d events expected",
                     $time, pending_beats.size(), expected_events.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic eoi);
        t_in_beat x;
        x.in_byte = b;
        x.end_of_input = eoi;
        pending_beats.push_back(x);
    endtask

    task automatic gen_field(input logic [7:0] delim, input logic [7:0] other);
        int sel;
        int n;
        int r;
        sel = $urandom_range(0, 9);
        n = $urandom_range(1, 6);
        if (sel == 0) begin
            // empty field
        end else if (sel < 4) begin
            push_beat(CH_QUOTE, 1'b0);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 19);
                case (r)
                    0: begin
                        push_beat(CH_QUOTE, 1'b0);
                        push_beat(CH_QUOTE, 1'b0);
                    end
                    1: push_beat(delim, 1'b0);
                    2: push_beat(CH_LF, 1'b0);
                    3: push_beat(CH_CR, 1'b0);
                    4: begin
                        push_beat(CH_BSLASH, 1'b0);
                        push_beat(8'($urandom_range(0, 255)), 1'b0);
                    end
                    5: push_beat(other, 1'b0);
                    default: push_beat(8'($urandom_range(8'h41, 8'h7A)), 1'b0);
                endcase
            end
            push_beat(CH_QUOTE, 1'b0);
            // stray text after the closing quote
            if ($urandom_range(0, 5) == 0)
                push_beat(8'($urandom_range(8'h30, 8'h39)), 1'b0);
        end else begin
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 15);
                case (r)
                    0: begin
                        push_beat(CH_BSLASH, 1'b0);
                        push_beat($urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255)),
                                  1'b0);
                    end
                    1: push_beat(other, 1'b0);
                    2: push_beat(CH_CR, 1'b0);
                    3: push_beat(CH_QUOTE, 1'b0);
                    4: push_beat(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
                    default: push_beat(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                endcase
            end
        end
    endtask

    task automatic gen_line();
        logic [7:0] delim;
        logic [7:0] other;
        int nf;
        int r;
        if ($urandom_range(0, 9) == 0) begin
            // noise: raw bytes and stray end marks
            repeat ($urandom_range(1, 6))
                push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            if (start_delim == DELIM_COMMA && $urandom_range(0, 3) != 0)
                delim = CH_COMMA;
            else if (start_delim == DELIM_SEMI && $urandom_range(0, 3) != 0)
                delim = CH_SEMI;
            else
                delim = $urandom_range(0, 1) ? CH_COMMA : CH_SEMI;
            other = (delim == CH_COMMA) ? CH_SEMI : CH_COMMA;
            nf = $urandom_range(1, 5);
            for (int f = 0; f < nf; f++) begin
                gen_field(delim, other);
                if (f != nf - 1) push_beat(delim, 1'b0);
            end
            r = $urandom_range(0, 9);
            if (r < 6) begin
                push_beat(CH_LF, 1'b0);
            end else if (r < 8) begin
                push_beat(CH_CR, 1'b0);
                push_beat(CH_LF, 1'b0);
            end else if (r == 8) begin
                push_beat(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(negedge i_clk);
        // beats that give no event may still sit in the pipe
        repeat (4) @(posedge i_clk);
    endtask

    logic [1:0] seg_cfg[5] = '{DELIM_COMMA, DELIM_SEMI, DELIM_UNUSED, DELIM_DETECT, DELIM_SEMI};

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part in detect mode
        send_idle_pct = 16;
        recv_stall_pct = 84;
        push_beat(8'h78, 1'b0);
        push_beat(CH_COMMA, 1'b0);
        push_beat(CH_SEMI, 1'b0);
        push_beat(CH_QUOTE, 1'b0);
        push_beat(CH_LF, 1'b0);
        push_beat(CH_QUOTE, 1'b0);
        push_beat(8'h61, 1'b0);
        push_beat(CH_SEMI, 1'b0);
        push_beat(CH_LF, 1'b0);
        push_beat(CH_QUOTE, 1'b0);
        push_beat(CH_QUOTE, 1'b0);
        push_beat(CH_QUOTE, 1'b0);
        push_beat(8'h7A, 1'b0);
        push_beat(CH_CR, 1'b0);
        push_beat(CH_SEMI, 1'b0);
        push_beat(CH_BSLASH, 1'b0);
        push_beat(CH_LF, 1'b0);
        push_beat(CH_BSLASH, 1'b0);
        push_beat(CH_COMMA, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(CH_CR, 1'b0);
        push_beat(CH_LF, 1'b0);
        push_beat(CH_BSLASH, 1'b0);
        push_beat(8'hFF, 1'b1);
        push_beat(8'h00, 1'b1);
        wait_drained();

        for (int s = 0; s < 5; s++) begin
            i_cfg_we <= 1'b1;
            i_cfg_data <= seg_cfg[s];
            start_delim = seg_cfg[s];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);
            if (s < 2) begin
                send_idle_pct = 16;
                recv_stall_pct = 84;
            end else if (s < 4) begin
                send_idle_pct = 84;
                recv_stall_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            while (pending_beats.size() < 165) gen_line();
            wait_drained();
        end

        $display("run covered %0d input beats and %0d events (%0d field ends, %0d line ends)",
                 n_beats, n_events, n_field_ends, n_line_ends);
        $display("under all four start delimiter codes and three idle patterns");
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cft_pkg.sv
hdl/cft_step.sv
hdl/csv_field_tokenizer.sv
test/csv_field_tokenizer_tb.sv
